### design/mlp_pkg.sv
// Package for the MLP forward-pass block: sizes, codes and the command and status structs.
// Used by the interfaces, the controller, the datapath and the top level.
package mlp_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 16;
    localparam int DATA_BITS  = 16;
    localparam int ACC_BITS   = 40;
    localparam int FRAC_BITS  = 8;

    localparam int LAYER_BITS = $clog2(MAX_LAYERS);
    localparam int IDX_BITS   = $clog2(MAX_WIDTH);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int NL_BITS    = 3;
    localparam int CFG_BITS   = 5;
    localparam int CFG_IDX_BITS = 3;
    localparam int RES_BITS   = DATA_BITS - 1;
    localparam int W_ADDR_BITS = LAYER_BITS + 2 * IDX_BITS;
    localparam int B_ADDR_BITS = LAYER_BITS + IDX_BITS;

    typedef enum logic [1:0] {
        K_WEIGHT = 2'd0,
        K_BIAS   = 2'd1,
        K_ELEM   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LAYERS = 3'd0,
        CFG_INW    = 3'd1,
        CFG_W0     = 3'd2,
        CFG_W1     = 3'd3,
        CFG_W2     = 3'd4,
        CFG_W3     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MAC,
        S_DRAIN,
        S_BIAS,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  load;     // input request accepted
        logic                  issue;    // start one multiply-accumulate
        logic                  clr_acc;
        logic                  add_bias;
        logic                  wr_res;
        logic                  out_load;
        logic                  out_last;
        logic                  src_b;    // current layer reads buffer B
        logic [LAYER_BITS-1:0] layer;
        logic [IDX_BITS-1:0]   row_i;
        logic [IDX_BITS-1:0]   col_j;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic acc_pos;
    } t_dp_sts;

endpackage

### design/mlp_in_if.sv
// Input channel interface: valid/ready plus one request (load or vector element).
// Depends on mlp_pkg for field widths.
interface mlp_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          kind;
    logic [mlp_pkg::LAYER_BITS-1:0]      layer_sel;
    logic [mlp_pkg::IDX_BITS-1:0]        row;
    logic [mlp_pkg::IDX_BITS-1:0]        col;
    logic signed [mlp_pkg::DATA_BITS-1:0] value;
    logic                                last;

    modport source (output valid, kind, layer_sel, row, col, value, last, input ready);
    modport sink   (input valid, kind, layer_sel, row, col, value, last, output ready);
endinterface

### design/mlp_out_if.sv
// Output channel interface: valid/ready plus one output vector element.
// Depends on mlp_pkg for field widths.
interface mlp_out_if;
    logic                           valid;
    logic                           ready;
    logic [mlp_pkg::RES_BITS-1:0]   result_value;
    logic [mlp_pkg::IDX_BITS-1:0]   result_index;
    logic                           result_last;

    modport source (output valid, result_value, result_index, result_last, input ready);
    modport sink   (input valid, result_value, result_index, result_last, output ready);
endinterface

### design/mlp_ctrl.sv
// Controller: configuration registers and the pass sequencer state machine.
// Depends on mlp_pkg; drives the datapath through t_dp_cmd.
module mlp_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mlp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mlp_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    input  logic [1:0]                        i_in_kind,
    input  logic                              i_in_last,
    output logic                              o_in_ready,
    input  mlp_pkg::t_dp_sts                  i_sts,
    output mlp_pkg::t_dp_cmd                  o_cmd
);
    import mlp_pkg::*;

    t_state                r_state, n_state;
    logic [NL_BITS-1:0]    r_layers;
    logic [CFG_BITS-1:0]   r_inw_cfg;
    logic [CFG_BITS-1:0]   r_wl [MAX_LAYERS];
    logic [LAYER_BITS-1:0] r_layer, n_layer;
    logic [IDX_BITS-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic                  r_d, n_d, r_src_b, n_src_b;
    logic [CNT_BITS-1:0]   r_inw, n_inw;
    logic [CNT_BITS-1:0]   inw_cl, outw_cl;
    logic [LAYER_BITS-1:0] last_layer;
    logic                  accept;

    function automatic logic [CNT_BITS-1:0] clamp_w(input logic [CFG_BITS-1:0] w);
        if (w == '0) begin
            return CNT_BITS'(1);
        end else if (w > CFG_BITS'(MAX_WIDTH)) begin
            return CNT_BITS'(MAX_WIDTH);
        end
        return CNT_BITS'(w);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers  <= NL_BITS'(MAX_LAYERS);
            r_inw_cfg <= CFG_BITS'(MAX_WIDTH);
            for (int n = 0; n < MAX_LAYERS; n++) begin
                r_wl[n] <= CFG_BITS'(MAX_WIDTH);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYERS: r_layers  <= i_cfg_data[NL_BITS-1:0];
                CFG_INW:    r_inw_cfg <= i_cfg_data;
                CFG_W0:     r_wl[0]   <= i_cfg_data;
                CFG_W1:     r_wl[1]   <= i_cfg_data;
                CFG_W2:     r_wl[2]   <= i_cfg_data;
                CFG_W3:     r_wl[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign inw_cl  = clamp_w(r_inw_cfg);
    assign outw_cl = clamp_w(r_wl[r_layer]);

    always_comb begin
        if (r_layers == '0) begin
            last_layer = '0;
        end else if (r_layers > NL_BITS'(MAX_LAYERS)) begin
            last_layer = LAYER_BITS'(MAX_LAYERS - 1);
        end else begin
            last_layer = LAYER_BITS'(r_layers - NL_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_d     <= 1'b0;
            r_src_b <= 1'b0;
            r_inw   <= CNT_BITS'(1);
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_d     <= n_d;
            r_src_b <= n_src_b;
            r_inw   <= n_inw;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_layer = r_layer;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_d     = r_d;
        n_src_b = r_src_b;
        n_inw   = r_inw;
        o_cmd   = '0;
        o_cmd.src_b = r_src_b;
        o_cmd.layer = r_layer;
        o_cmd.row_i = r_i;
        o_cmd.col_j = r_j;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept && i_in_kind == K_ELEM && i_in_last) begin
                    n_state = S_CLEAR;
                    n_layer = '0;
                    n_i     = '0;
                    n_src_b = 1'b0;
                    n_inw   = inw_cl;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_acc = 1'b1;
                n_j     = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if (CNT_BITS'(r_j) == r_inw - CNT_BITS'(1)) begin
                    n_d     = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + IDX_BITS'(1);
                end
            end
            S_DRAIN: begin
                // Waits for the read and product stages to empty.
                n_d = 1'b1;
                if (r_d) begin
                    n_state = S_BIAS;
                end
            end
            S_BIAS: begin
                o_cmd.add_bias = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_res = 1'b1;
                if (CNT_BITS'(r_i) == outw_cl - CNT_BITS'(1)) begin
                    n_src_b = !r_src_b;
                    n_inw   = outw_cl;
                    n_i     = '0;
                    if (r_layer == last_layer) begin
                        n_k     = '0;
                        n_state = S_OUT;
                    end else begin
                        n_layer = r_layer + LAYER_BITS'(1);
                        n_state = S_CLEAR;
                    end
                end else begin
                    n_i     = r_i + IDX_BITS'(1);
                    n_state = S_CLEAR;
                end
            end
            S_OUT: begin
                o_cmd.col_j    = r_k;
                o_cmd.out_last = (CNT_BITS'(r_k) == r_inw - CNT_BITS'(1));
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (o_cmd.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + IDX_BITS'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready while a pass is running");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_kind == K_ELEM && i_in_last) |=> (r_state == S_CLEAR))
        else $error("last element did not start a pass");

    a_write_after_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_BIAS))
        else $error("result written without bias step");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten");

endmodule

### design/mlp_dp.sv
// Datapath: weight and bias memories, activation ping-pong buffers, MAC pipeline,
// accumulator and output register. Depends on mlp_pkg; commanded by mlp_ctrl.
module mlp_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mlp_pkg::t_dp_cmd                      i_cmd,
    output mlp_pkg::t_dp_sts                      o_sts,
    input  logic [1:0]                            i_kind,
    input  logic [mlp_pkg::LAYER_BITS-1:0]        i_layer_sel,
    input  logic [mlp_pkg::IDX_BITS-1:0]          i_row,
    input  logic [mlp_pkg::IDX_BITS-1:0]          i_col,
    input  logic signed [mlp_pkg::DATA_BITS-1:0]  i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [mlp_pkg::RES_BITS-1:0]          o_result_value,
    output logic [mlp_pkg::IDX_BITS-1:0]          o_result_index,
    output logic                                  o_result_last
);
    import mlp_pkg::*;

    localparam int W_DEPTH = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
    localparam int B_DEPTH = MAX_LAYERS * MAX_WIDTH;

    logic signed [DATA_BITS-1:0]   wmem [W_DEPTH];
    logic signed [DATA_BITS-1:0]   bmem [B_DEPTH];
    logic signed [DATA_BITS-1:0]   act_a [MAX_WIDTH];
    logic signed [DATA_BITS-1:0]   act_b [MAX_WIDTH];

    logic signed [DATA_BITS-1:0]   r_w, r_x, r_bias;
    logic signed [2*DATA_BITS-1:0] r_prod;
    logic                          r_v1, r_v2;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic [RES_BITS-1:0]           res;
    logic signed [DATA_BITS-1:0]   out_src;
    logic                          r_ov;
    logic [RES_BITS-1:0]           r_oval;
    logic [IDX_BITS-1:0]           r_oidx;
    logic                          r_olast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_kind == K_WEIGHT) begin
            wmem[{i_layer_sel, i_row, i_col}] <= i_value;
        end
        r_w <= wmem[{i_cmd.layer, i_cmd.row_i, i_cmd.col_j}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_kind == K_BIAS) begin
            bmem[{i_layer_sel, i_row}] <= i_value;
        end
        r_bias <= bmem[{i_cmd.layer, i_cmd.row_i}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_kind == K_ELEM) begin
            act_a[i_row] <= i_value;
        end else if (i_cmd.wr_res && i_cmd.src_b) begin
            act_a[i_cmd.row_i] <= $signed({1'b0, res});
        end
        if (i_cmd.wr_res && !i_cmd.src_b) begin
            act_b[i_cmd.row_i] <= $signed({1'b0, res});
        end
        r_x <= i_cmd.src_b ? act_b[i_cmd.col_j] : act_a[i_cmd.col_j];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_w * r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.clr_acc) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + ACC_BITS'(r_prod);
            end else if (i_cmd.add_bias) begin
                r_acc <= r_acc + (ACC_BITS'(r_bias) <<< FRAC_BITS);
            end
        end
    end

    // ReLU, drop the fraction shift, saturate to the largest positive value.
    assign o_sts.acc_pos = !r_acc[ACC_BITS-1] && (r_acc != '0);
    always_comb begin
        if (!o_sts.acc_pos) begin
            res = '0;
        end else if (r_acc[ACC_BITS-2:FRAC_BITS+RES_BITS] != '0) begin
            res = '1;
        end else begin
            res = r_acc[FRAC_BITS+RES_BITS-1:FRAC_BITS];
        end
    end

    assign out_src = i_cmd.src_b ? act_b[i_cmd.col_j] : act_a[i_cmd.col_j];
    assign o_sts.out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oval  <= out_src[RES_BITS-1:0];
            r_oidx  <= i_cmd.col_j;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_valid        = r_ov;
    assign o_result_value = r_oval;
    assign o_result_index = r_oidx;
    assign o_result_last  = r_olast;

    a_v2_follows_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage valid without read stage");

    a_hold_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_oval) && $stable(r_oidx)))
        else $error("pending output element changed");

    a_no_bias_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_bias |-> !r_v2)
        else $error("bias added while products still in flight");

endmodule

### design/mlp_forward_relu.sv
// Top level of the dense MLP forward pass with ReLU, Q8.8, one shared MAC.
// Requests are accepted one per cycle while idle; a pass computes the outputs one at a
// time (one weight memory port, one multiplier), then sends one output element per cycle unless the output stalls.
// Reset returns control to idle and configuration to its defaults; weights, biases
// and activations are undefined until written. The accumulator resets to zero.
module mlp_forward_relu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mlp_in_if.sink                            i_in,
    mlp_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [mlp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mlp_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import mlp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mlp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_in.kind),
        .i_layer_sel    (i_in.layer_sel),
        .i_row          (i_in.row),
        .i_col          (i_in.col),
        .i_value        (i_in.value),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_result_value (o_out.result_value),
        .o_result_index (o_out.result_index),
        .o_result_last  (o_out.result_last)
    );

endmodule

### sim/mlp_forward_check.sv
// Checker for the MLP forward-pass block: watches the request, result and register ports.
// Predicts every output vector in Q8.8 and compares it element by element. Needs mlp_pkg and the interfaces.
module mlp_forward_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mlp_in_if                                 i_mon_in,
    mlp_out_if                                i_mon_out,
    input  logic                              i_cfg_we,
    input  logic [mlp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mlp_pkg::CFG_BITS-1:0]      i_cfg_data,
    output int                                o_mismatches,
    output int                                o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    typedef struct packed {
        logic [RES_BITS-1:0] value;
        logic [IDX_BITS-1:0] index;
        logic                last;
    } t_elem;

    logic signed [DATA_BITS-1:0] weights [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
    logic signed [DATA_BITS-1:0] biases [MAX_LAYERS][MAX_WIDTH];
    // Two activation buffers; layer outputs overwrite them, so they persist across passes.
    logic signed [DATA_BITS-1:0] act [2][MAX_WIDTH];
    logic [NL_BITS-1:0]  num_layers;
    logic [CFG_BITS-1:0] in_width;
    logic [CFG_BITS-1:0] layer_width [MAX_LAYERS];
    t_elem exp_outputs[$];

    function automatic int clamp_w(logic [CFG_BITS-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return w;
    endfunction

    task automatic forward_pass();
        logic signed [ACC_BITS-1:0]    acc;
        logic signed [ACC_BITS-1:0]    bias_ext;
        logic signed [2*DATA_BITS-1:0] prod;
        int nl, in_w, out_w, src;
        t_elem e;
        nl = (num_layers == 0) ? 1 : ((num_layers > MAX_LAYERS) ? MAX_LAYERS : num_layers);
        in_w = clamp_w(in_width);
        src = 0;
        for (int l = 0; l < nl; l++) begin
            out_w = clamp_w(layer_width[l]);
            for (int i = 0; i < out_w; i++) begin
                acc = '0;
                for (int j = 0; j < in_w; j++) begin
                    prod = weights[l][i][j] * act[src][j];
                    acc = acc + prod;
                end
                bias_ext = biases[l][i];
                acc = acc + (bias_ext <<< FRAC_BITS);
                if (acc <= 0)
                    act[1-src][i] = '0;
                else if ((acc >>> FRAC_BITS) > 32767)
                    act[1-src][i] = 16'sh7fff;
                else
                    act[1-src][i] = acc[FRAC_BITS +: DATA_BITS];
            end
            src = 1 - src;
            in_w = out_w;
        end
        for (int i = 0; i < in_w; i++) begin
            e.value = act[src][i][RES_BITS-1:0];
            e.index = i[IDX_BITS-1:0];
            e.last  = (i + 1 == in_w);
            exp_outputs.push_back(e);
        end
    endtask

    assign o_awaiting = exp_outputs.size();

    initial o_mismatches = 0;

    always @(posedge i_clk) begin
        t_elem want;
        if (!i_rst_n) begin
            num_layers <= 3'd4;
            in_width   <= 5'd16;
            for (int l = 0; l < MAX_LAYERS; l++) layer_width[l] <= 5'd16;
            exp_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LAYERS: num_layers <= i_cfg_data[NL_BITS-1:0];
                    CFG_INW:    in_width <= i_cfg_data;
                    CFG_W0:     layer_width[0] <= i_cfg_data;
                    CFG_W1:     layer_width[1] <= i_cfg_data;
                    CFG_W2:     layer_width[2] <= i_cfg_data;
                    CFG_W3:     layer_width[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (exp_outputs.size() == 0) begin
                    $display("%0t: unexpected result value=%0d index=%0d last=%0b", $time,
                             i_mon_out.result_value, i_mon_out.result_index,
                             i_mon_out.result_last);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = exp_outputs.pop_front();
                    if (want.value !== i_mon_out.result_value
                        || want.index !== i_mon_out.result_index
                        || want.last !== i_mon_out.result_last) begin
                        $display("%0t: result mismatch: expected value=%0d index=%0d last=%0b,",
                                 $time, want.value, want.index, want.last,
                                 " actual value=%0d index=%0d last=%0b",
                                 i_mon_out.result_value, i_mon_out.result_index,
                                 i_mon_out.result_last);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            // Requests use the configuration as it stood before this edge.
            if (i_mon_in.valid && i_mon_in.ready) begin
                case (i_mon_in.kind)
                    K_WEIGHT: weights[i_mon_in.layer_sel][i_mon_in.row][i_mon_in.col] =
                                  i_mon_in.value;
                    K_BIAS:   biases[i_mon_in.layer_sel][i_mon_in.row] = i_mon_in.value;
                    K_ELEM: begin
                        act[0][i_mon_in.row] = i_mon_in.value;
                        if (i_mon_in.last) forward_pass();
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

### sim/testbench.sv
// Top of the MLP forward-pass test: clock, reset, register writes and request stimulus.
// Checking is done by mlp_forward_check; needs mlp_pkg, the interfaces and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 76;
    localparam int CYCLE_LIMIT  = 1000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;
    int mismatches, awaiting, cycles, items;
    int idle_req_pct, idle_res_pct;

    // Which entries hold a written value, and the effective sizes of the current setting.
    bit w_ok [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
    bit b_ok [MAX_LAYERS][MAX_WIDTH];
    int eff_layers, eff_inw;
    int eff_w [MAX_LAYERS];

    mlp_in_if  req_if ();
    mlp_out_if res_if ();

    mlp_forward_relu u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mlp_forward_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mon_in     (req_if),
        .i_mon_out    (res_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_awaiting   (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mlp_forward_relu test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= idle_res_pct);
    end

    function automatic int clamp_w(int w);
        return (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_req(logic [1:0] kind, int layer, int row, int col,
                            logic [15:0] value, bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_req_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.kind      <= kind;
        req_if.layer_sel <= layer[LAYER_BITS-1:0];
        req_if.row       <= row[IDX_BITS-1:0];
        req_if.col       <= col[IDX_BITS-1:0];
        req_if.value     <= value;
        req_if.last      <= last;
        do @(posedge i_clk); while (!req_if.ready);
        if (kind == K_WEIGHT) w_ok[layer][row][col] = 1'b1;
        if (kind == K_BIAS) b_ok[layer][row] = 1'b1;
        if (kind != KIND_NONE) items++;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_config(int nl, int inw, int w0, int w1, int w2, int w3);
        int vals [6];
        vals = '{nl, inw, w0, w1, w2, w3};
        wait_quiet();
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(k);
            i_cfg_data <= vals[k][CFG_BITS-1:0];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        eff_layers = (nl < 1) ? 1 : ((nl > MAX_LAYERS) ? MAX_LAYERS : nl);
        eff_inw = clamp_w(inw);
        eff_w = '{clamp_w(w0), clamp_w(w1), clamp_w(w2), clamp_w(w3)};
    endtask

    // One pass: refresh missing or some random parameters, add noise, then the vector.
    task automatic run_pass();
        int in_w, order[$], tmp, n;
        in_w = eff_inw;
        for (int l = 0; l < eff_layers; l++) begin
            for (int i = 0; i < eff_w[l]; i++) begin
                for (int j = 0; j < in_w; j++)
                    if (!w_ok[l][i][j] || $urandom_range(5) == 0)
                        send_req(K_WEIGHT, l, i, j, pick_value(), $urandom_range(1));
                if (!b_ok[l][i] || $urandom_range(3) == 0)
                    send_req(K_BIAS, l, i, $urandom_range(15), pick_value(), $urandom_range(1));
            end
            in_w = eff_w[l];
        end
        if ($urandom_range(3) == 0)
            send_req(KIND_NONE, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                     16'($urandom), $urandom_range(1));
        if (eff_inw < MAX_WIDTH && $urandom_range(3) == 0)
            send_req(K_ELEM, $urandom_range(3), $urandom_range(MAX_WIDTH - 1, eff_inw),
                     $urandom_range(15), pick_value(), 1'b0);
        for (int j = 0; j < eff_inw; j++) order.push_back(j);
        for (int j = eff_inw - 1; j > 0; j--) begin
            n = $urandom_range(j);
            tmp = order[j];
            order[j] = order[n];
            order[n] = tmp;
        end
        foreach (order[k])
            send_req(K_ELEM, $urandom_range(3), order[k], $urandom_range(15), pick_value(),
                     k == eff_inw - 1);
    endtask

    function automatic int pick_width();
        if ($urandom_range(11) == 0) return ($urandom_range(1) ? 0 : $urandom_range(16, 31));
        return $urandom_range(1, 5);
    endfunction

    initial begin
        int start;
        cycles = 0;
        items = 0;
        idle_req_pct = 13;
        idle_res_pct = 70;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.kind = K_WEIGHT;
        req_if.layer_sel = '0;
        req_if.row = '0;
        req_if.col = '0;
        req_if.value = '0;
        req_if.last = 1'b0;
        res_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single neuron: saturation, negative sum to zero, an all-zero sum, and an in-range sum after noise.
        set_config(1, 1, 1, 1, 1, 1);
        send_req(K_WEIGHT, 0, 0, 0, 16'h7fff, 1'b1);
        send_req(K_BIAS, 0, 0, 0, 16'h7fff, 1'b0);
        send_req(K_ELEM, 0, 0, 0, 16'h7fff, 1'b1);
        send_req(K_WEIGHT, 0, 0, 0, 16'h8000, 1'b0);
        send_req(K_BIAS, 0, 0, 0, 16'h8000, 1'b0);
        send_req(K_ELEM, 0, 0, 0, 16'h7fff, 1'b1);
        send_req(K_WEIGHT, 0, 0, 0, 16'h0000, 1'b0);
        send_req(K_BIAS, 0, 0, 0, 16'h0000, 1'b0);
        send_req(K_ELEM, 0, 0, 0, 16'h8000, 1'b1);
        send_req(K_WEIGHT, 0, 0, 0, 16'h0100, 1'b0);
        send_req(K_BIAS, 0, 0, 0, 16'h0080, 1'b0);
        send_req(KIND_NONE, 3, 15, 15, 16'hffff, 1'b1);
        send_req(K_ELEM, 3, 15, 15, 16'h1234, 1'b0);
        send_req(K_ELEM, 0, 0, 0, 16'h0355, 1'b1);
        // Zero sizes count as one; layer count and widths above range are clamped.
        set_config(0, 0, 0, 0, 0, 0);
        run_pass();
        set_config(7, 1, 1, 1, 1, 31);
        run_pass();
        set_config(4, 16, 1, 1, 1, 16);
        run_pass();

        start = items;
        while (items - start < RANDOM_ITEMS) begin
            if (items - start < RANDOM_ITEMS / 3) begin
                idle_req_pct = 13;
                idle_res_pct = 70;
            end else if (items - start < 2 * RANDOM_ITEMS / 3) begin
                idle_req_pct = 70;
                idle_res_pct = 13;
            end else begin
                idle_req_pct = 0;
                idle_res_pct = 0;
            end
            if ($urandom_range(2) == 0)
                set_config($urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(1, 4),
                           pick_width(), pick_width(), pick_width(), pick_width(),
                           pick_width());
            run_pass();
        end

        wait_quiet();
        if (mismatches == 0)
            $display("mlp_forward_relu test passed");
        else
            $display("mlp_forward_relu test failed");
        $finish;
    end
endmodule

### filelist.f
design/mlp_pkg.sv
design/mlp_in_if.sv
design/mlp_out_if.sv
design/mlp_ctrl.sv
design/mlp_dp.sv
design/mlp_forward_relu.sv
sim/mlp_forward_check.sv
sim/testbench.sv
